/* rtl/core/dri_pkg.sv */
package dri_pkg;

  typedef struct packed {
    logic signed [31:0] angle_count;
    logic signed [31:0] length_count;
    logic signed [15:0] mag_x;
    logic signed [15:0] mag_y;
  } in_word_t;

  typedef struct packed {
    logic signed [47:0] pos_x;
    logic signed [47:0] pos_y;
    logic signed [15:0] heading_angle;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic vec_start;
    logic vec_step;
    logic rot_start;
    logic rot_step;
    logic mul_step;
    logic acc_step;
  } dp_cmd_t;

  localparam int unsigned TabLen = 24;
  localparam logic [31:0] DeltaToBam = 32'd447981339;
  localparam logic [31:0] InvGain = 32'd652032874;

  function automatic logic [31:0] atan_entry(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0: r = 32'h20000000;
      5'd1: r = 32'h12E4051E;
      5'd2: r = 32'h09FB385B;
      5'd3: r = 32'h051111D4;
      5'd4: r = 32'h028B0D43;
      5'd5: r = 32'h0145D7E1;
      5'd6: r = 32'h00A2F61E;
      5'd7: r = 32'h00517C55;
      5'd8: r = 32'h0028BE53;
      5'd9: r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/dri_datapath.sv */
module dri_datapath #(
  parameter int unsigned POS_WIDTH = 48
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dri_pkg::dp_cmd_t cmd_i,
  input  logic [4:0]       step_i,
  input  dri_pkg::in_word_t in_i,
  output dri_pkg::out_word_t out_o
);

  logic [31:0] prev_angle_q, prev_length_q, theta_q;
  logic signed [POS_WIDTH-1:0] x_acc_q, y_acc_q;
  logic signed [32:0] da_q, dl_q;
  logic signed [15:0] mx_q, my_q;
  logic signed [33:0] vx_q, vy_q;
  logic [31:0] vz_q;
  logic [15:0] hd_q;
  logic signed [32:0] rx_q, ry_q, rz_q;
  logic neg_q;
  logic signed [65:0] px_q, py_q;

  logic [63:0] mag;
  logic [31:0] bam;
  logic signed [33:0] vxs, vys;
  logic signed [32:0] rxs, rys;
  logic [31:0] at;
  logic [31:0] z32, phi;
  logic [15:0] hd_new;
  logic signed [32:0] cx, cy;
  logic signed [65:0] sx, sy;
  logic signed [POS_WIDTH:0] ax, ay;
  logic signed [POS_WIDTH-1:0] hi, lo;
  logic signed [POS_WIDTH-1:0] x_nx, y_nx;
  logic signed [63:0] xo, yo;
  logic [31:0] phi_f;
  logic        fold;

  assign at  = dri_pkg::atan_entry(step_i);
  assign vxs = vx_q >>> step_i;
  assign vys = vy_q >>> step_i;
  assign rxs = rx_q >>> step_i;
  assign rys = ry_q >>> step_i;
  assign mag = {31'd0, (da_q[32] ? -da_q : da_q)} * {32'd0, dri_pkg::DeltaToBam};
  assign bam = mag[47:16] + {31'd0, mag[15]};
  assign z32 = vz_q + 32'h8000;
  assign hd_new = (mx_q == 16'sd0 && my_q == 16'sd0) ? 16'd0 : z32[31:16];
  assign phi = {hd_new, 16'd0} - theta_q;

  // Angles outside [-pi/2, pi/2) are turned by pi and the outputs negated.
  assign fold  = phi[31] ^ phi[30];
  assign phi_f = fold ? phi - 32'h80000000 : phi;

  always_comb begin
    cx = (rx_q > 33'sd1073741824) ? 33'sd1073741824 :
         (rx_q < -33'sd1073741824) ? -33'sd1073741824 : rx_q;
    cy = (ry_q > 33'sd1073741824) ? 33'sd1073741824 :
         (ry_q < -33'sd1073741824) ? -33'sd1073741824 : ry_q;
    if (neg_q) begin
      cx = -cx;
      cy = -cy;
    end
  end

  assign sx = (px_q + 66'sd536870912) >>> 30;
  assign sy = (py_q + 66'sd536870912) >>> 30;
  assign hi = {1'b0, {(POS_WIDTH-1){1'b1}}};
  assign lo = {1'b1, {(POS_WIDTH-1){1'b0}}};
  assign ax = {x_acc_q[POS_WIDTH-1], x_acc_q} + sx[POS_WIDTH:0];
  assign ay = {y_acc_q[POS_WIDTH-1], y_acc_q} + sy[POS_WIDTH:0];

  always_comb begin
    if (sx > 66'sd0 && ax[POS_WIDTH] != ax[POS_WIDTH-1]) begin
      x_nx = hi;
    end else if (sx < 66'sd0 && ax[POS_WIDTH] != ax[POS_WIDTH-1]) begin
      x_nx = lo;
    end else begin
      x_nx = ax[POS_WIDTH-1:0];
    end
    if (sy > 66'sd0 && ay[POS_WIDTH] != ay[POS_WIDTH-1]) begin
      y_nx = hi;
    end else if (sy < 66'sd0 && ay[POS_WIDTH] != ay[POS_WIDTH-1]) begin
      y_nx = lo;
    end else begin
      y_nx = ay[POS_WIDTH-1:0];
    end
  end

  assign xo = 64'(x_acc_q);
  assign yo = 64'(y_acc_q);
  assign out_o = {xo[47:0], yo[47:0], hd_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_angle_q <= '0;
      prev_length_q <= '0;
      theta_q <= '0;
      x_acc_q <= '0;
      y_acc_q <= '0;
    end else begin
      if (cmd_i.load) begin
        prev_angle_q <= in_i.angle_count;
        prev_length_q <= in_i.length_count;
      end
      if (cmd_i.vec_start) begin
        theta_q <= da_q[32] ? theta_q - bam : theta_q + bam;
      end
      if (cmd_i.acc_step) begin
        x_acc_q <= x_nx;
        y_acc_q <= y_nx;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      da_q <= {in_i.angle_count[31], in_i.angle_count} - {prev_angle_q[31], prev_angle_q};
      dl_q <= {in_i.length_count[31], in_i.length_count} - {prev_length_q[31], prev_length_q};
      mx_q <= in_i.mag_x;
      my_q <= in_i.mag_y;
    end
    if (cmd_i.vec_start) begin
      if (mx_q[15]) begin
        vx_q <= -{{2{mx_q[15]}}, mx_q, 16'd0};
        vy_q <= -{{2{my_q[15]}}, my_q, 16'd0};
        vz_q <= 32'h80000000;
      end else begin
        vx_q <= {{2{mx_q[15]}}, mx_q, 16'd0};
        vy_q <= {{2{my_q[15]}}, my_q, 16'd0};
        vz_q <= '0;
      end
    end else if (cmd_i.vec_step) begin
      if (!vy_q[33]) begin
        vx_q <= vx_q + vys;
        vy_q <= vy_q - vxs;
        vz_q <= vz_q + at;
      end else begin
        vx_q <= vx_q - vys;
        vy_q <= vy_q + vxs;
        vz_q <= vz_q - at;
      end
    end
    if (cmd_i.rot_start) begin
      hd_q <= hd_new;
      rx_q <= {1'b0, dri_pkg::InvGain};
      ry_q <= '0;
      rz_q <= {phi_f[31], phi_f};
      neg_q <= fold;
    end else if (cmd_i.rot_step) begin
      if (!rz_q[32]) begin
        rx_q <= rx_q - rys;
        ry_q <= ry_q + rxs;
        rz_q <= rz_q - {1'b0, at};
      end else begin
        rx_q <= rx_q + rys;
        ry_q <= ry_q - rxs;
        rz_q <= rz_q + {1'b0, at};
      end
    end
    if (cmd_i.mul_step) begin
      px_q <= dl_q * cx;
      py_q <= dl_q * cy;
    end
  end

endmodule

/* rtl/core/dri_ctrl.sv */
module dri_ctrl #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output dri_pkg::dp_cmd_t cmd_o,
  output logic [4:0]       step_o
);

  localparam int unsigned Steps = (CORDIC_STEPS > dri_pkg::TabLen) ?
                                  dri_pkg::TabLen : CORDIC_STEPS;
  localparam logic [4:0] LastStep = 5'(Steps - 1);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_VINIT = 7'b0000010,
    S_VEC = 7'b0000100,
    S_RINIT = 7'b0001000,
    S_ROT = 7'b0010000,
    S_MUL = 7'b0100000,
    S_ACC = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic [4:0] step_q, step_d;
  logic out_valid_q, out_valid_d;
  logic take;

  assign take = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign step_o = step_q;

  always_comb begin
    state_d = state_q;
    step_d = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.load = take;
        if (take) begin
          state_d = S_VINIT;
        end
      end
      S_VINIT: begin
        cmd_o.vec_start = 1'b1;
        step_d = '0;
        state_d = S_VEC;
      end
      S_VEC: begin
        cmd_o.vec_step = 1'b1;
        step_d = step_q + 5'd1;
        if (step_q == LastStep) begin
          state_d = S_RINIT;
        end
      end
      S_RINIT: begin
        cmd_o.rot_start = 1'b1;
        step_d = '0;
        state_d = S_ROT;
      end
      S_ROT: begin
        cmd_o.rot_step = 1'b1;
        step_d = step_q + 5'd1;
        if (step_q == LastStep) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d = S_ACC;
      end
      S_ACC: begin
        cmd_o.acc_step = 1'b1;
        out_valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/dead_reckoning_integrator.sv */
// Dead-reckoning integrator with a compass heading.
// The input channel (in_valid_i, in_stall_o, in_word_i) carries one word per
// tick: cumulative odometry angle and length counts and a magnetometer pair.
// The output channel (out_valid_o, out_stall_i, out_word_o) returns one word
// per input word: the integrated x/y position and the compass heading.
// The result of an accepted word passes through a setup state and
// CORDIC_STEPS iterations (capped at TabLen) for the vectoring CORDIC, the
// same for the rotation CORDIC on one shared sequencer, a multiply state and
// an accumulate state, after which out_valid_o is raised.
// One word is processed at a time and the next word is accepted only after
// the result has left.
// While a result waits under out_stall_i, the result register holds and no
// new input word is accepted.
// Reset clears the previous counts, the heading correction and the position
// accumulators to zero and leaves the output channel empty.
module dead_reckoning_integrator #(
  parameter int unsigned CORDIC_STEPS = 16,
  parameter int unsigned POS_WIDTH = 48
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dri_pkg::in_word_t   in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dri_pkg::out_word_t  out_word_o
);

  dri_pkg::dp_cmd_t cmd;
  logic [4:0] step;

  dri_ctrl #(.CORDIC_STEPS(CORDIC_STEPS)) u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i),
    .cmd_o(cmd), .step_o(step)
  );

  dri_datapath #(.POS_WIDTH(POS_WIDTH)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .step_i(step),
    .in_i(in_word_i), .out_o(out_word_o)
  );

endmodule
